// ----- rtl/swmr_pkg.sv -----
// package for the sliding window mean and range unit
// holds widths, window length and the command and status structs
// no dependencies
package swmr_pkg;

   localparam int WINDOW   = 19;
   localparam int SAMPLE_W = 56;
   localparam int COUNT_W  = 5;
   localparam int SLOT_W   = $clog2(WINDOW);
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
   localparam int DIV_W    = SUM_W + (SUM_W % 2);
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int DCNT_W   = $clog2(DIV_STEPS + 1);

   typedef struct packed {
      logic load;
      logic rd_old;
      logic update;
      logic scan;
      logic div_start;
      logic div_step;
      logic out_load;
   } swmr_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic div_last;
   } swmr_status_type;

endpackage

// ----- rtl/swmr_ctrl.sv -----
// controller state machine of the sliding window mean and range unit
// sequences read of the oldest entry, update, scan, divide and result load
// depends on swmr_pkg
module swmr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  swmr_pkg::swmr_status_type status,
   output swmr_pkg::swmr_cmd_type    cmd
);
   import swmr_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RD_OLD = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       out_vld_ff, out_vld_in;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_vld_ff;
   assign out_free  = !out_vld_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RD_OLD;
            end
         end
         ST_RD_OLD: begin
            cmd.rd_old = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (rsp_valid && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

endmodule

// ----- rtl/swmr_datapath.sv -----
// datapath of the sliding window mean and range unit
// window memory, running sum, min and max scan, radix-4 divider, result registers
// depends on swmr_pkg
module swmr_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  swmr_pkg::swmr_cmd_type        cmd,
   output swmr_pkg::swmr_status_type     status,
   input  logic [swmr_pkg::SAMPLE_W-1:0] req_sample,
   output logic [swmr_pkg::SAMPLE_W-1:0] rsp_mean_value,
   output logic [swmr_pkg::SAMPLE_W-1:0] rsp_spread,
   output logic [swmr_pkg::COUNT_W-1:0]  rsp_held_count
);
   import swmr_pkg::*;

   localparam logic [CNT_W-1:0]  WIN_CNT   = CNT_W'(WINDOW);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
   localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(DIV_STEPS - 1);

   logic [SAMPLE_W-1:0] mem [WINDOW];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                rd_en;
   logic [SLOT_W-1:0]   rd_addr;

   logic [SAMPLE_W-1:0] sample_ff;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                full;
   logic [SUM_W-1:0]    old_ext;

   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic                scan_more;
   logic [SAMPLE_W-1:0] hi_ff, hi_in, lo_ff, lo_in;

   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [CNT_W:0]      t1, t2, dvs;
   logic [CNT_W-1:0]    r1, r2;
   logic                ge1, ge2;

   logic [CNT_W+COUNT_W-1:0] fill_wide;

   // window memory
   assign full      = (fill_ff == WIN_CNT);
   assign scan_more = (idx_ff < fill_ff);
   assign rd_en     = cmd.rd_old || (cmd.scan && scan_more);
   assign rd_addr   = cmd.rd_old ? slot_ff : idx_ff[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         mem[slot_ff] <= sample_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // window bookkeeping and running sum
   assign old_ext = {{(SUM_W - SAMPLE_W){1'b0}}, rd_data_ff};

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (cmd.update) begin
         slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         fill_in = full ? fill_ff : fill_ff + 1'b1;
         sum_in  = (full ? sum_ff - old_ext : sum_ff)
                   + {{(SUM_W - SAMPLE_W){1'b0}}, sample_ff};
      end
   end

   // min and max scan over held entries
   always_comb begin
      idx_in  = idx_ff;
      pend_in = pend_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (cmd.update) begin
         idx_in  = '0;
         pend_in = 1'b0;
         hi_in   = '0;
         lo_in   = '1;
      end else if (cmd.scan) begin
         pend_in = scan_more;
         if (scan_more) begin
            idx_in = idx_ff + 1'b1;
         end
         if (pend_ff) begin
            if (rd_data_ff > hi_ff) begin
               hi_in = rd_data_ff;
            end
            if (rd_data_ff < lo_ff) begin
               lo_in = rd_data_ff;
            end
         end
      end
   end

   assign status.scan_done = !scan_more && !pend_ff;

   // two quotient bits per cycle
   assign dvs = {1'b0, fill_ff};
   assign t1  = {rem_ff, quo_ff[DIV_W-1]};
   assign ge1 = (t1 >= dvs);
   assign r1  = ge1 ? CNT_W'(t1 - dvs) : CNT_W'(t1);
   assign t2  = {r1, quo_ff[DIV_W-2]};
   assign ge2 = (t2 >= dvs);
   assign r2  = ge2 ? CNT_W'(t2 - dvs) : CNT_W'(t2);

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_start) begin
         rem_in  = '0;
         quo_in  = {{(DIV_W - SUM_W){1'b0}}, sum_ff};
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = r2;
         quo_in  = {quo_ff[DIV_W-3:0], ge1, ge2};
         dcnt_in = dcnt_ff + 1'b1;
      end
   end

   assign status.div_last = (dcnt_ff == LAST_STEP);

   assign fill_wide = {{COUNT_W{1'b0}}, fill_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample;
      end
      idx_ff  <= idx_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dcnt_ff <= dcnt_in;
      if (cmd.out_load) begin
         rsp_mean_value <= quo_ff[SAMPLE_W-1:0];
         rsp_spread     <= hi_ff - lo_ff;
         rsp_held_count <= fill_wide[COUNT_W-1:0];
      end
   end

endmodule

// ----- rtl/sliding_window_mean_range_unit.sv -----
// sliding window mean and range unit
// a request passes through read of the oldest entry, update, the one-port window scan
// and the two-bits-per-cycle divider before its result is loaded
// one item at a time; a waiting result does not block the next input
// reset (synchronous, active high) empties the window and clears the running sum
// no clearing pass: window entries are only used once written
module sliding_window_mean_range_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [swmr_pkg::SAMPLE_W-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [swmr_pkg::SAMPLE_W-1:0] rsp_mean_value,
   output logic [swmr_pkg::SAMPLE_W-1:0] rsp_spread,
   output logic [swmr_pkg::COUNT_W-1:0]  rsp_held_count
);
   import swmr_pkg::*;

   swmr_cmd_type    cmd;
   swmr_status_type status;

   swmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   swmr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_sample),
      .rsp_mean_value (rsp_mean_value),
      .rsp_spread     (rsp_spread),
      .rsp_held_count (rsp_held_count)
   );

endmodule
